// File: hw/rtl/utfcc_pkg.sv
package utfcc_pkg;

  // Encoding selector values held in the mode register.
  localparam logic [1:0] MODE_UTF8    = 2'd0;
  localparam logic [1:0] MODE_UTF16LE = 2'd1;
  localparam logic [1:0] MODE_UTF16BE = 2'd2;

  // Leading byte order mark of a UTF-8 text.
  localparam logic [7:0] MARK_B0 = 8'hEF;
  localparam logic [7:0] MARK_B1 = 8'hBB;
  localparam logic [7:0] MARK_B2 = 8'hBF;

  // UTF-16 units of interest.
  localparam logic [15:0] UNIT_BOM     = 16'hFEFF;
  localparam logic [15:0] UNIT_BOM_REV = 16'hFFFE;
  localparam logic [5:0]  HIGH_PREFIX  = 6'b110110;
  localparam logic [5:0]  LOW_PREFIX   = 6'b110111;

  // Position of the byte within the text, saturating at three.
  localparam logic [1:0] POS_MANY = 2'd3;

  // Control passed from the input stage to the decoders.
  typedef struct packed {
    logic       adv;    // the held byte is consumed this cycle
    logic       last;   // the held byte ends the text
    logic       clear;  // the text is abandoned (register write)
    logic [1:0] pos;    // byte position, three or more reads as POS_MANY
  } utfcc_ctl_t;

  // Length of the sequence announced by a UTF-8 lead byte.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/utfcc_utf8.sv
module utfcc_utf8
  import utfcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  utfcc_ctl_t ctl,
  input  logic [7:0] byte_in,
  output logic [1:0] inc
);

  logic [2:0] seq_len_r, seq_len_nxt;
  logic [1:0] held_total_r, held_total_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic       mark_r, mark_nxt;
  logic [2:0] held_inc;
  logic [2:0] len_now;
  logic [1:0] tail;
  logic       mark_miss;

  // Check the byte against the leading mark while still inside its first three bytes.
  always_comb begin
    unique case (ctl.pos)
      2'd0:    mark_miss = (byte_in != MARK_B0);
      2'd1:    mark_miss = (byte_in != MARK_B1);
      2'd2:    mark_miss = (byte_in != MARK_B2);
      default: mark_miss = 1'b0;
    endcase
  end

  assign held_inc = {1'b0, held_total_r} + 3'd1;
  assign len_now  = lead_length(byte_in);

  // A cut-short sequence rescans its held bytes: one held byte is one character,
  // two held bytes are one character only if the first opens a two-byte sequence.
  assign tail = (held_inc == 3'd1) ? 2'd1 :
                ((lead_length(held0_r) == 3'd2) ? 2'd1 : 2'd2);

  // Per-byte decoding step.
  always_comb begin
    seq_len_nxt    = seq_len_r;
    held_total_nxt = held_total_r;
    held0_nxt      = held0_r;
    mark_nxt       = mark_r & ~mark_miss;
    inc            = 2'd0;
    if (seq_len_r != 3'd0) begin
      if (held_inc + 3'd1 >= seq_len_r) begin
        // Sequence complete; the leading mark itself is not counted.
        inc            = (ctl.pos == 2'd2 && mark_nxt) ? 2'd0 : 2'd1;
        seq_len_nxt    = 3'd0;
        held_total_nxt = 2'd0;
      end else begin
        if (held_total_r == 2'd0) begin
          held0_nxt = byte_in;
        end
        held_total_nxt = held_inc[1:0];
        if (ctl.last) begin
          inc = 2'd1 + tail;
        end
      end
    end else begin
      if (len_now == 3'd1 || ctl.last) begin
        inc = 2'd1;
      end else begin
        seq_len_nxt    = len_now;
        held_total_nxt = 2'd0;
      end
    end
  end

  // Decoder state; a register write or the end of the text starts afresh.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear || (ctl.adv && ctl.last)) begin
      seq_len_r    <= 3'd0;
      held_total_r <= 2'd0;
      mark_r       <= 1'b1;
    end else if (ctl.adv) begin
      seq_len_r    <= seq_len_nxt;
      held_total_r <= held_total_nxt;
      mark_r       <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      held0_r <= held0_nxt;
    end
  end

  // Held bytes never reach three, since a four-byte sequence completes on its last byte.
  assert property (@(posedge clk) disable iff (!rst_n) held_total_r != 2'd3)
    else $error("utfcc_utf8: held byte count out of range");

  // No bytes are held without a pending lead.
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r == 3'd0 |-> held_total_r == 2'd0)
    else $error("utfcc_utf8: held bytes without a pending sequence");

  // A pending lead is always a multi-byte lead.
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r != 3'd1 && seq_len_r <= 3'd4)
    else $error("utfcc_utf8: bad pending sequence length");

endmodule

// File: hw/rtl/utfcc_utf16.sv
module utfcc_utf16
  import utfcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  utfcc_ctl_t ctl,
  input  logic       little,
  input  logic [7:0] byte_in,
  output logic       inc
);

  logic [7:0]  odd_half_r;
  logic        half_r, half_nxt;
  logic        high_r, high_nxt;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;

  // Join the held byte and this byte into one unit.
  assign unit    = little ? {byte_in, odd_half_r} : {odd_half_r, byte_in};
  assign is_high = (unit[15:10] == HIGH_PREFIX);
  assign is_low  = (unit[15:10] == LOW_PREFIX);

  // Unit classification: pairs count once, marks and stray high or low halves are skipped.
  always_comb begin
    half_nxt = ~half_r;
    high_nxt = high_r;
    inc      = 1'b0;
    if (half_r) begin
      if (high_r && is_low) begin
        high_nxt = 1'b0;
        inc      = 1'b1;
      end else if (unit == UNIT_BOM || unit == UNIT_BOM_REV) begin
        high_nxt = 1'b0;
      end else if (is_high) begin
        high_nxt = 1'b1;
      end else if (is_low) begin
        high_nxt = 1'b0;
      end else begin
        high_nxt = 1'b0;
        inc      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear || (ctl.adv && ctl.last)) begin
      half_r <= 1'b0;
      high_r <= 1'b0;
    end else if (ctl.adv) begin
      half_r <= half_nxt;
      high_r <= high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && !half_r) begin
      odd_half_r <= byte_in;
    end
  end

endmodule

// File: hw/rtl/utf_character_counter.sv
// An accepted byte is held in the input register; a last byte's result is loaded into the
// output register when that byte moves on, and out_tvalid is driven from that register.
// Throughput: one byte per cycle, set by the single input register feeding the decoders.
// A waiting result stalls the input only when the next byte is also a last byte.
// Reset (rst_n low at a clock edge) selects UTF-8, empties both registers and clears
// all counting state; there is no clearing pass.
module utf_character_counter
  import utfcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] char_count, [32] too_large, [39:33] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata   // encoding_mode
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [1:0]  mode_r;
  logic [31:0] bytes_r;
  logic        bytes_ovf_r;
  logic [31:0] count_r;
  logic        out_valid_r;
  logic [31:0] out_count_r;
  logic        out_large_r;

  logic        adv;
  utfcc_ctl_t  ctl;
  logic [1:0]  inc8;
  logic        inc16;
  logic [1:0]  inc;
  logic [31:0] count_nxt;
  logic        large_nxt;

  // The held byte moves on unless it would produce a result with the output still full.
  assign adv       = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign ctl.adv   = adv;
  assign ctl.last  = in_last_r;
  assign ctl.clear = cfg_we;
  assign ctl.pos   = (bytes_ovf_r || bytes_r[31:2] != 30'd0) ? POS_MANY : bytes_r[1:0];

  utfcc_utf8 u_utf8 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .byte_in (in_byte_r),
    .inc     (inc8)
  );

  utfcc_utf16 u_utf16 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .little  (mode_r == MODE_UTF16LE),
    .byte_in (in_byte_r),
    .inc     (inc16)
  );

  // Pick the decoder for the selected encoding; the unused code falls back to UTF-8.
  always_comb begin
    unique case (mode_r)
      MODE_UTF16LE: inc = {1'b0, inc16};
      MODE_UTF16BE: inc = {1'b0, inc16};
      default:      inc = inc8;
    endcase
  end

  assign count_nxt = count_r + {30'd0, inc};
  assign large_nxt = bytes_ovf_r || (&bytes_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Encoding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF8;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Byte and character counters of the current text; the byte count saturates.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || (adv && in_last_r)) begin
      bytes_r     <= 32'd0;
      bytes_ovf_r <= 1'b0;
      count_r     <= 32'd0;
    end else if (adv) begin
      if (&bytes_r) begin
        bytes_ovf_r <= 1'b1;
      end else begin
        bytes_r <= bytes_r + 32'd1;
      end
      count_r <= count_nxt;
    end
  end

  // Output register: loaded by a last byte, emptied by a completed transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_count_r <= large_nxt ? 32'd0 : count_nxt;
      out_large_r <= large_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_large_r, out_count_r};

  // An accepted byte always lands in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_valid_r)
    else $error("utf_character_counter: accepted byte lost");

  // A consumed last byte always leaves a result waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> out_valid_r)
    else $error("utf_character_counter: result not produced");

  // A result is never overwritten before it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(adv && in_last_r))
    else $error("utf_character_counter: pending result overwritten");

  // The overflow flag is only set once the byte count is at its top.
  assert property (@(posedge clk) disable iff (!rst_n)
    bytes_ovf_r |-> (&bytes_r))
    else $error("utf_character_counter: byte counter overflow inconsistent");

endmodule
